FILE: rtl/epfa_pkg.sv
// Shared constants and types for the event polarity frame accumulator.
// Used by epfa_rmw and event_polarity_frame_accumulator; no dependencies.

package epfa_pkg;

	localparam int MAX_WIDTH_DEF    = 512;
	localparam int MAX_HEIGHT_DEF   = 512;
	localparam int BALANCE_BITS_DEF = 16;

	localparam int DIM_BITS       = 10;
	localparam int POS_BITS       = 12;
	localparam int PIX_BITS       = 8;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [DIM_BITS-1:0]       CFG_DIM_RESET    = 10'd512;

	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [PIX_BITS-1:0] PIX_MORE_ON  = 8'd255;
	localparam logic [PIX_BITS-1:0] PIX_MORE_OFF = 8'd0;
	localparam logic [PIX_BITS-1:0] PIX_BALANCED = 8'd127;

	typedef struct packed {
		logic valid;
		logic cmd;
		logic pol;
	} epfa_req_t;

	typedef struct packed {
		logic                valid;
		logic [PIX_BITS-1:0] value;
	} epfa_rsp_t;

endpackage

FILE: rtl/epfa_rmw.sv
// Balance store with its read-modify-write pipeline and the clearing pass after reset.
// Depends on epfa_pkg.

module epfa_rmw #(
	parameter int MAX_WIDTH    = epfa_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT   = epfa_pkg::MAX_HEIGHT_DEF,
	parameter int BALANCE_BITS = epfa_pkg::BALANCE_BITS_DEF,
	parameter int ADDR_W       = (MAX_WIDTH * MAX_HEIGHT > 1) ?
		$clog2(MAX_WIDTH * MAX_HEIGHT) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  epfa_pkg::epfa_req_t req,
	input  logic [ADDR_W-1:0]   addr,
	output logic                busy,
	output epfa_pkg::epfa_rsp_t rsp
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic signed [BALANCE_BITS-1:0] BAL_MAX = {1'b0, {(BALANCE_BITS-1){1'b1}}};
	localparam logic signed [BALANCE_BITS-1:0] BAL_MIN = {1'b1, {(BALANCE_BITS-1){1'b0}}};

	logic signed [BALANCE_BITS-1:0] mem [DEPTH];

	logic                           clr_busy_q;
	logic [ADDR_W-1:0]              clr_addr_q;
	logic                           v_s3;
	logic                           cmd_s3;
	logic                           pol_s3;
	logic [ADDR_W-1:0]              addr_s3;
	logic signed [BALANCE_BITS-1:0] rd_s3;
	logic                           byp_s3;
	logic signed [BALANCE_BITS-1:0] byp_val_s3;
	logic signed [BALANCE_BITS-1:0] bal;
	logic signed [BALANCE_BITS-1:0] new_bal;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			v_s3       <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == LAST_ADDR) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (adv) begin
				v_s3 <= req.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s3      <= mem[addr];
			byp_s3     <= v_s3 && (addr == addr_s3);
			byp_val_s3 <= new_bal;
			addr_s3    <= addr;
			cmd_s3     <= req.cmd;
			pol_s3     <= req.pol;
		end
	end

	always_comb begin
		bal = byp_s3 ? byp_val_s3 : rd_s3;
		if (cmd_s3 == epfa_pkg::CMD_READ) begin
			new_bal = '0;
		end else if (pol_s3) begin
			new_bal = (bal == BAL_MAX) ? bal : bal + 1'b1;
		end else begin
			new_bal = (bal == BAL_MIN) ? bal : bal - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (adv && v_s3) begin
			mem[addr_s3] <= new_bal;
		end
	end

	assign busy      = clr_busy_q;
	assign rsp.valid = v_s3 && (cmd_s3 == epfa_pkg::CMD_READ);
	assign rsp.value = (bal > 0) ? epfa_pkg::PIX_MORE_ON :
		((bal < 0) ? epfa_pkg::PIX_MORE_OFF : epfa_pkg::PIX_BALANCED);

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_busy_q |=> !clr_busy_q)
		else $error("clearing pass restarted without reset");

	a_empty_while_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !v_s3)
		else $error("update stage busy during clearing pass");

endmodule

FILE: rtl/event_polarity_frame_accumulator.sv
// Top level of the event polarity frame accumulator: configuration, coordinate
// clamping, address stage and output register. Depends on epfa_pkg and epfa_rmw.
//
//  channel   words            handshake                   direction
//  item      cmd,pos_x,pos_y, item_valid / item_stall     into block
//            polarity_on
//  result    pixel_value      result_valid / result_stall out of block
//  config    cfg_index,       cfg_wr_en                   into block
//            cfg_data
//
// One item per cycle while item_stall is low; a read word passes the clamp, address,
// update and output registers before it appears on the result port.
// The store has one read and one write port; back-to-back hits on the same
// pixel are forwarded from the update stage.
// After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries (262144 at the
// defaults) runs with item_stall high; configuration writes are taken.
// While a read waits in the update stage and the output word is stalled,
// the pipeline holds and item_stall is high.

module event_polarity_frame_accumulator #(
	parameter int MAX_WIDTH    = epfa_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT   = epfa_pkg::MAX_HEIGHT_DEF,
	parameter int BALANCE_BITS = epfa_pkg::BALANCE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [epfa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [epfa_pkg::DIM_BITS-1:0]         cfg_data,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic                                  cmd,
	input  logic signed [epfa_pkg::POS_BITS-1:0]  pos_x,
	input  logic signed [epfa_pkg::POS_BITS-1:0]  pos_y,
	input  logic                                  polarity_on,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic [epfa_pkg::PIX_BITS-1:0]         pixel_value
);

	localparam int DW     = epfa_pkg::DIM_BITS;
	localparam int PW     = epfa_pkg::POS_BITS;
	localparam int ADDR_W = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;

	function automatic logic [DW-1:0] active_dim(input logic [DW-1:0] r, input int limit);
		logic [DW-1:0] d;
		if (r == '0) begin
			d = DW'(1);
		end else if (int'(r) > limit) begin
			d = DW'(limit);
		end else begin
			d = r;
		end
		return d;
	endfunction

	function automatic logic [DW-1:0] clamp_coord(input logic signed [PW-1:0] c,
		input logic [DW-1:0] dim);
		logic [DW-1:0] top;
		logic [DW-1:0] r;
		top = dim - 1'b1;
		if (c[PW-1]) begin
			r = '0;
		end else if ({1'b0, c[PW-2:0]} > PW'(top)) begin
			r = top;
		end else begin
			r = DW'(c);
		end
		return r;
	endfunction

	logic [DW-1:0]         w_q;
	logic [DW-1:0]         h_q;
	logic                  adv;
	logic                  busy;
	logic                  accept;
	logic                  v_s1;
	logic                  cmd_s1;
	logic                  pol_s1;
	logic [DW-1:0]         x_s1;
	logic [DW-1:0]         y_s1;
	logic                  v_s2;
	logic                  cmd_s2;
	logic                  pol_s2;
	logic [ADDR_W-1:0]     addr_s2;
	logic [2*DW-1:0]       prod;
	logic [2*DW:0]         lin;
	logic                  out_valid_q;
	logic [epfa_pkg::PIX_BITS-1:0] out_value_q;
	epfa_pkg::epfa_req_t   req;
	epfa_pkg::epfa_rsp_t   rsp;

	assign adv        = !(rsp.valid && out_valid_q && result_stall);
	assign item_stall = busy || !adv;
	assign accept     = item_valid && !item_stall;
	assign prod       = y_s1 * w_q;
	assign lin        = {1'b0, prod} + (2*DW+1)'(x_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= active_dim(epfa_pkg::CFG_DIM_RESET, MAX_WIDTH);
			h_q         <= active_dim(epfa_pkg::CFG_DIM_RESET, MAX_HEIGHT);
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					epfa_pkg::CFG_FRAME_WIDTH: w_q <= active_dim(cfg_data, MAX_WIDTH);
					epfa_pkg::CFG_FRAME_HEIGHT: h_q <= active_dim(cfg_data, MAX_HEIGHT);
					default: ;
				endcase
			end
			if (adv) begin
				v_s1 <= accept;
				v_s2 <= v_s1;
			end
			if (adv && rsp.valid) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= cmd;
			pol_s1  <= polarity_on;
			x_s1    <= clamp_coord(pos_x, w_q);
			y_s1    <= clamp_coord(pos_y, h_q);
			cmd_s2  <= cmd_s1;
			pol_s2  <= pol_s1;
			addr_s2 <= ADDR_W'(lin);
		end
		if (adv && rsp.valid) begin
			out_value_q <= rsp.value;
		end
	end

	assign req.valid = v_s2;
	assign req.cmd   = cmd_s2;
	assign req.pol   = pol_s2;

	epfa_rmw #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.BALANCE_BITS (BALANCE_BITS),
		.ADDR_W       (ADDR_W)
	) u_rmw (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.req    (req),
		.addr   (addr_s2),
		.busy   (busy),
		.rsp    (rsp)
	);

	assign result_valid = out_valid_q;
	assign pixel_value  = out_value_q;

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> item_stall)
		else $error("item accepted during clearing pass");

	a_pipe_empty_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (!v_s1 && !v_s2))
		else $error("pipeline holds words during clearing pass");

	a_read_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && rsp.valid) |=> result_valid)
		else $error("retired read did not reach the output register");

endmodule
